@@ rtl/cci_pkg.sv @@
// shared constants, result codes and saturation helper for the
// circle intersection pipeline; no dependencies
package cci_pkg;

  // field widths of the request and result
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 15;
  localparam int TOL_W    = 8;

  // tolerance after reset, in coordinate lsbs
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

  // number of points found
  typedef enum logic [1:0] {
    COUNT_NONE = 2'd0,
    COUNT_ONE  = 2'd1,
    COUNT_TWO  = 2'd2
  } count_t;

  // clamp a wide signed coordinate to the 16 bit range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [47:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

@@ rtl/cci_sqrt.sv @@
// pipelined integer square root, one result bit per register stage
// carries a valid bit and a side bus alongside; no package dependencies
module cci_sqrt #(
  parameter int RAD_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     rad_in,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   root_out,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int R = RAD_W / 2;

  logic              vld_q  [R];
  logic [SIDE_W-1:0] side_q [R];
  logic [R:0]        rem_q  [R];
  logic [R-1:0]      root_q [R];
  logic [RAD_W-1:0]  word_q [R];

  for (genvar s = 0; s < R; s++) begin : g_stage
    logic              pv;
    logic [SIDE_W-1:0] pside;
    logic [R:0]        prem;
    logic [R-1:0]      proot;
    logic [RAD_W-1:0]  pword;
    logic [R+2:0]      t;
    logic [R+2:0]      trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign pside = side_in;
      assign prem  = '0;
      assign proot = '0;
      assign pword = rad_in;
    end else begin : g_next
      assign pv    = vld_q[s-1];
      assign pside = side_q[s-1];
      assign prem  = rem_q[s-1];
      assign proot = root_q[s-1];
      assign pword = word_q[s-1];
    end

    // bring down two radicand bits and try the next root bit
    assign t     = {prem, pword[RAD_W-1:RAD_W-2]};
    assign trial = {1'b0, proot, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      side_q[s] <= pside;
      rem_q[s]  <= ge ? (R+1)'(t - trial) : t[R:0];
      root_q[s] <= {proot[R-2:0], ge};
      word_q[s] <= {pword[RAD_W-3:0], 2'b00};
    end
  end

  assign out_valid = vld_q[R-1];
  assign root_out  = root_q[R-1];
  assign side_out  = side_q[R-1];

endmodule

@@ rtl/cci_div.sv @@
// pipelined restoring divider, one quotient bit per register stage,
// several dividends share one divisor; no package dependencies
module cci_div #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]  num_in,
  input  logic [DEN_W-1:0]             den_in,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_valid,
  output logic [LANES-1:0][NUM_W-1:0]  quo_out,
  output logic [SIDE_W-1:0]            side_out
);

  logic              vld_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W][LANES];
  logic [NUM_W-1:0]  word_q [NUM_W][LANES];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              pv;
    logic [DEN_W-1:0]  pden;
    logic [SIDE_W-1:0] pside;
    logic [DEN_W-1:0]  nrem  [LANES];
    logic [NUM_W-1:0]  nword [LANES];

    if (s == 0) begin : g_first
      assign pv    = in_valid;
      assign pden  = den_in;
      assign pside = side_in;
    end else begin : g_next
      assign pv    = vld_q[s-1];
      assign pden  = den_q[s-1];
      assign pside = side_q[s-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W-1:0] pr;
      logic [NUM_W-1:0] pw;
      logic [DEN_W:0]   t;
      logic             ge;

      if (s == 0) begin : g_first
        assign pr = '0;
        assign pw = num_in[l];
      end else begin : g_next
        assign pr = rem_q[s-1][l];
        assign pw = word_q[s-1][l];
      end

      // shift in the next dividend bit, subtract when it fits
      assign t        = {pr, pw[NUM_W-1]};
      assign ge       = (t >= {1'b0, pden});
      assign nrem[l]  = ge ? DEN_W'(t - {1'b0, pden}) : t[DEN_W-1:0];
      assign nword[l] = {pw[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      den_q[s]  <= pden;
      side_q[s] <= pside;
      for (int l = 0; l < LANES; l++) begin
        rem_q[s][l]  <= nrem[l];
        word_q[s][l] <= nword[l];
      end
    end
  end

  assign out_valid = vld_q[NUM_W-1];
  assign side_out  = side_q[NUM_W-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_out[l] = word_q[NUM_W-1][l];
    end
  end

endmodule

@@ rtl/circle_circle_intersection.sv @@
// circle intersection top level: front end, distance root, offset divider,
// height root and point dividers; uses cci_pkg, cci_sqrt, cci_div
//
// Usage:
//   A request (two circles, center and radius each) is taken at a rising
//   edge with start high and busy low. busy never rises, so a request can
//   be given in every cycle.
//   Each request gives exactly one result: done is high for one cycle with
//   point_count and the point fields; the receiver cannot hold it off.
//   Throughput is one request per cycle. The pipe is built from the
//   bit-serial stages, 25 for the distance root, 51 for the offset
//   divider, 23 for the height root and 46 for the point dividers, and
//   16 stages of squaring, multiplying, adding and the result register
//   around them.
//   The tolerance register is written with cfg_write and cfg_data and is
//   sampled per request at acceptance.
//   Reset clears every valid bit in the pipe, so requests in flight are
//   dropped, and sets the tolerance to 1.
module circle_circle_intersection (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_write,
  input  logic [cci_pkg::TOL_W-1:0]           cfg_data,
  input  logic signed [cci_pkg::COORD_W-1:0]  first_x,
  input  logic signed [cci_pkg::COORD_W-1:0]  first_y,
  input  logic [cci_pkg::RADIUS_W-1:0]        first_radius,
  input  logic signed [cci_pkg::COORD_W-1:0]  second_x,
  input  logic signed [cci_pkg::COORD_W-1:0]  second_y,
  input  logic [cci_pkg::RADIUS_W-1:0]        second_radius,
  output logic                                done,
  output logic [1:0]                          point_count,
  output logic signed [cci_pkg::COORD_W-1:0]  point_a_x,
  output logic signed [cci_pkg::COORD_W-1:0]  point_a_y,
  output logic signed [cci_pkg::COORD_W-1:0]  point_b_x,
  output logic signed [cci_pkg::COORD_W-1:0]  point_b_y
);

  // side data carried through the distance root
  typedef struct packed {
    logic               reject;
    logic signed [35:0] num;
    logic [29:0]        r1sq;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic [7:0]         tol;
  } side1_t;

  // side data carried through the offset divider
  typedef struct packed {
    logic               asign;
    logic               reject;
    logic [29:0]        r1sq;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic [7:0]         tol;
    logic [24:0]        d8;
  } side2_t;

  // side data carried through the height root
  typedef struct packed {
    logic               reject;
    logic signed [26:0] a8;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic [7:0]         tol;
    logic [24:0]        d8;
  } side3_t;

  // side data carried through the point dividers
  typedef struct packed {
    logic               reject;
    logic               tangent;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic [3:0]         sgn;
  } side4_t;

  logic accept;
  logic [7:0] tolerance;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits of the plain stages
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14, v15;
  logic vd, vdiv1, vh, vdiv2;

  // request capture and tolerance register
  logic signed [15:0] x1_1, y1_1, x2_1, y2_1;
  logic [14:0]        r1_1, r2_1;
  logic [7:0]         tol_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= cci_pkg::TOL_RESET;
    end else if (cfg_write) begin
      tolerance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x1_1  <= first_x;
      y1_1  <= first_y;
      r1_1  <= first_radius;
      x2_1  <= second_x;
      y2_1  <= second_y;
      r2_1  <= second_radius;
      tol_1 <= tolerance;
    end
  end

  // center offset and separation thresholds
  logic signed [16:0] dx_2, dy_2;
  logic [16:0]        lo_2, hi_2;
  logic [14:0]        r1_2, r2_2;
  logic signed [15:0] x1_2, y1_2;
  logic [7:0]         tol_2;
  logic [16:0]        rdiff_c;

  always_comb begin
    if (r1_1 >= r2_1) begin
      rdiff_c = {2'b00, r1_1} - {2'b00, r2_1};
    end else begin
      rdiff_c = {2'b00, r2_1} - {2'b00, r1_1};
    end
  end

  always_ff @(posedge clk) begin
    dx_2  <= $signed({x2_1[15], x2_1}) - $signed({x1_1[15], x1_1});
    dy_2  <= $signed({y2_1[15], y2_1}) - $signed({y1_1[15], y1_1});
    lo_2  <= rdiff_c + {9'd0, tol_1};
    hi_2  <= {2'b00, r1_1} + {2'b00, r2_1} + {9'd0, tol_1};
    r1_2  <= r1_1;
    r2_2  <= r2_1;
    x1_2  <= x1_1;
    y1_2  <= y1_1;
    tol_2 <= tol_1;
  end

  // squares
  logic signed [33:0] dxsq_3, dysq_3;
  logic [33:0]        losq_3, hisq_3;
  logic [29:0]        r1sq_3, r2sq_3;
  logic signed [16:0] dx_3, dy_3;
  logic signed [15:0] x1_3, y1_3;
  logic [7:0]         tol_3;

  always_ff @(posedge clk) begin
    dxsq_3 <= dx_2 * dx_2;
    dysq_3 <= dy_2 * dy_2;
    losq_3 <= lo_2 * lo_2;
    hisq_3 <= hi_2 * hi_2;
    r1sq_3 <= r1_2 * r1_2;
    r2sq_3 <= r2_2 * r2_2;
    dx_3   <= dx_2;
    dy_3   <= dy_2;
    x1_3   <= x1_2;
    y1_3   <= y1_2;
    tol_3  <= tol_2;
  end

  // squared distance and difference of the squared radii
  logic [33:0]        dq_4, losq_4, hisq_4;
  logic signed [30:0] rsqd_4;
  logic [29:0]        r1sq_4;
  logic signed [16:0] dx_4, dy_4;
  logic signed [15:0] x1_4, y1_4;
  logic [7:0]         tol_4;

  always_ff @(posedge clk) begin
    dq_4   <= $unsigned(dxsq_3) + $unsigned(dysq_3);
    rsqd_4 <= $signed({1'b0, r1sq_3}) - $signed({1'b0, r2sq_3});
    losq_4 <= losq_3;
    hisq_4 <= hisq_3;
    r1sq_4 <= r1sq_3;
    dx_4   <= dx_3;
    dy_4   <= dy_3;
    x1_4   <= x1_3;
    y1_4   <= y1_3;
    tol_4  <= tol_3;
  end

  // separation test and offset numerator
  logic [33:0] dq_5;
  side1_t      side1_5;

  always_ff @(posedge clk) begin
    dq_5           <= dq_4;
    side1_5.reject <= (dq_4 == '0) || (dq_4 < losq_4) || (dq_4 > hisq_4);
    side1_5.num    <= $signed({2'b00, dq_4}) + $signed({{5{rsqd_4[30]}}, rsqd_4});
    side1_5.r1sq   <= r1sq_4;
    side1_5.dx     <= dx_4;
    side1_5.dy     <= dy_4;
    side1_5.x1     <= x1_4;
    side1_5.y1     <= y1_4;
    side1_5.tol    <= tol_4;
  end

  // distance root: d with 8 extra fraction bits
  logic [24:0]            d8_d;
  logic [$bits(side1_t)-1:0] side1_vec;
  side1_t                 side1_d;

  cci_sqrt #(
    .RAD_W  (50),
    .SIDE_W ($bits(side1_t))
  ) u_dist_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .rad_in    ({dq_5, 16'd0}),
    .side_in   (side1_5),
    .out_valid (vd),
    .root_out  (d8_d),
    .side_out  (side1_vec)
  );

  assign side1_d = side1_vec;

  // numerator magnitude
  logic [34:0] numabs_6;
  logic [24:0] d8_6;
  side1_t      side1_6;

  always_ff @(posedge clk) begin
    numabs_6 <= side1_d.num[35] ? 35'(-side1_d.num) : side1_d.num[34:0];
    d8_6     <= d8_d;
    side1_6  <= side1_d;
  end

  // scaled numerator plus half divisor for rounding
  logic [50:0] amag_7;
  side2_t      side2_7;

  always_ff @(posedge clk) begin
    amag_7         <= {1'b0, numabs_6, 15'd0} + {27'd0, d8_6[24:1]};
    side2_7.asign  <= side1_6.num[35];
    side2_7.reject <= side1_6.reject;
    side2_7.r1sq   <= side1_6.r1sq;
    side2_7.dx     <= side1_6.dx;
    side2_7.dy     <= side1_6.dy;
    side2_7.x1     <= side1_6.x1;
    side2_7.y1     <= side1_6.y1;
    side2_7.tol    <= side1_6.tol;
    side2_7.d8     <= d8_6;
  end

  // offset divider: a with 8 extra fraction bits
  logic [0:0][50:0]          aq_d;
  logic [$bits(side2_t)-1:0] side2_vec;
  side2_t                    side2_d;

  cci_div #(
    .NUM_W  (51),
    .DEN_W  (25),
    .LANES  (1),
    .SIDE_W ($bits(side2_t))
  ) u_offset_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .num_in    (amag_7),
    .den_in    (side2_7.d8),
    .side_in   (side2_7),
    .out_valid (vdiv1),
    .quo_out   (aq_d),
    .side_out  (side2_vec)
  );

  assign side2_d = side2_vec;

  // signed offset
  logic signed [26:0] a8_8;
  side2_t             side2_8;

  always_ff @(posedge clk) begin
    a8_8    <= side2_d.asign ? -$signed(aq_d[0][26:0]) : $signed(aq_d[0][26:0]);
    side2_8 <= side2_d;
  end

  // offset squared
  logic signed [53:0] a8sq_9;
  logic signed [26:0] a8_9;
  side2_t             side2_9;

  always_ff @(posedge clk) begin
    a8sq_9  <= a8_8 * a8_8;
    a8_9    <= a8_8;
    side2_9 <= side2_8;
  end

  // height radicand, clamped at zero
  logic signed [54:0] h2_c;
  logic [45:0]        hrad_10;
  side3_t             side3_10;

  assign h2_c = $signed({9'd0, side2_9.r1sq, 16'd0}) - a8sq_9;

  always_ff @(posedge clk) begin
    hrad_10         <= (!h2_c[54] && (h2_c != '0)) ? h2_c[45:0] : '0;
    side3_10.reject <= side2_9.reject;
    side3_10.a8     <= a8_9;
    side3_10.dx     <= side2_9.dx;
    side3_10.dy     <= side2_9.dy;
    side3_10.x1     <= side2_9.x1;
    side3_10.y1     <= side2_9.y1;
    side3_10.tol    <= side2_9.tol;
    side3_10.d8     <= side2_9.d8;
  end

  // height root: h with 8 extra fraction bits
  logic [22:0]               h8_h;
  logic [$bits(side3_t)-1:0] side3_vec;
  side3_t                    side3_h;

  cci_sqrt #(
    .RAD_W  (46),
    .SIDE_W ($bits(side3_t))
  ) u_height_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v10),
    .rad_in    (hrad_10),
    .side_in   (side3_10),
    .out_valid (vh),
    .root_out  (h8_h),
    .side_out  (side3_vec)
  );

  assign side3_h = side3_vec;

  // products of offset and height with the center offset
  logic signed [23:0] h8s_c;
  logic signed [43:0] pa_11, pb_11, pc_11, pd_11;
  logic               tangent_11, reject_11;
  logic signed [15:0] x1_11, y1_11;
  logic [24:0]        d8_11;

  assign h8s_c = $signed({1'b0, h8_h});

  always_ff @(posedge clk) begin
    pa_11      <= side3_h.a8 * side3_h.dx;
    pb_11      <= h8s_c * side3_h.dy;
    pc_11      <= side3_h.a8 * side3_h.dy;
    pd_11      <= h8s_c * side3_h.dx;
    tangent_11 <= h8_h <= {7'd0, side3_h.tol, 8'd0};
    reject_11  <= side3_h.reject;
    x1_11      <= side3_h.x1;
    y1_11      <= side3_h.y1;
    d8_11      <= side3_h.d8;
  end

  // point numerators, lane order a_x a_y b_x b_y
  logic signed [44:0] n_12 [4];
  logic               tangent_12, reject_12;
  logic signed [15:0] x1_12, y1_12;
  logic [24:0]        d8_12;

  always_ff @(posedge clk) begin
    n_12[0]    <= pa_11 - pb_11;
    n_12[1]    <= pc_11 + pd_11;
    n_12[2]    <= pa_11 + pb_11;
    n_12[3]    <= pc_11 - pd_11;
    tangent_12 <= tangent_11;
    reject_12  <= reject_11;
    x1_12      <= x1_11;
    y1_12      <= y1_11;
    d8_12      <= d8_11;
  end

  // numerator magnitudes and signs
  logic [44:0]        m_13 [4];
  logic [3:0]         sgn_13;
  logic               tangent_13, reject_13;
  logic signed [15:0] x1_13, y1_13;
  logic [24:0]        d8_13;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      m_13[l]   <= n_12[l][44] ? 45'(-n_12[l]) : 45'(n_12[l]);
      sgn_13[l] <= n_12[l][44];
    end
    tangent_13 <= tangent_12;
    reject_13  <= reject_12;
    x1_13      <= x1_12;
    y1_13      <= y1_12;
    d8_13      <= d8_12;
  end

  // add half divisor for rounding
  logic [3:0][45:0] pm_14;
  logic [24:0]      d8_14;
  side4_t           side4_14;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      pm_14[l] <= {1'b0, m_13[l]} + {22'd0, d8_13[24:1]};
    end
    d8_14            <= d8_13;
    side4_14.reject  <= reject_13;
    side4_14.tangent <= tangent_13;
    side4_14.x1      <= x1_13;
    side4_14.y1      <= y1_13;
    side4_14.sgn     <= sgn_13;
  end

  // point dividers, four lanes sharing d
  logic [3:0][45:0]          pq_d;
  logic [$bits(side4_t)-1:0] side4_vec;
  side4_t                    side4_d;

  cci_div #(
    .NUM_W  (46),
    .DEN_W  (25),
    .LANES  (4),
    .SIDE_W ($bits(side4_t))
  ) u_point_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v14),
    .num_in    (pm_14),
    .den_in    (d8_14),
    .side_in   (side4_14),
    .out_valid (vdiv2),
    .quo_out   (pq_d),
    .side_out  (side4_vec)
  );

  assign side4_d = side4_vec;

  // add the first center back
  logic signed [47:0] fin_15 [4];
  logic               tangent_15, reject_15;

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (side4_d.sgn[l]) begin
        fin_15[l] <= ((l % 2 == 0) ? 48'(side4_d.x1) : 48'(side4_d.y1))
                     - $signed({2'b00, pq_d[l]});
      end else begin
        fin_15[l] <= ((l % 2 == 0) ? 48'(side4_d.x1) : 48'(side4_d.y1))
                     + $signed({2'b00, pq_d[l]});
      end
    end
    tangent_15 <= side4_d.tangent;
    reject_15  <= side4_d.reject;
  end

  // result register: count, saturation, unused fields cleared
  always_ff @(posedge clk) begin
    if (reject_15) begin
      point_count <= cci_pkg::COUNT_NONE;
      point_a_x   <= '0;
      point_a_y   <= '0;
      point_b_x   <= '0;
      point_b_y   <= '0;
    end else if (tangent_15) begin
      point_count <= cci_pkg::COUNT_ONE;
      point_a_x   <= cci_pkg::sat_coord(fin_15[0]);
      point_a_y   <= cci_pkg::sat_coord(fin_15[1]);
      point_b_x   <= '0;
      point_b_y   <= '0;
    end else begin
      point_count <= cci_pkg::COUNT_TWO;
      point_a_x   <= cci_pkg::sat_coord(fin_15[0]);
      point_a_y   <= cci_pkg::sat_coord(fin_15[1]);
      point_b_x   <= cci_pkg::sat_coord(fin_15[2]);
      point_b_y   <= cci_pkg::sat_coord(fin_15[3]);
    end
  end

  // valid bits of the plain stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      v8   <= 1'b0;
      v9   <= 1'b0;
      v10  <= 1'b0;
      v11  <= 1'b0;
      v12  <= 1'b0;
      v13  <= 1'b0;
      v14  <= 1'b0;
      v15  <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      v6   <= vd;
      v7   <= v6;
      v8   <= vdiv1;
      v9   <= v8;
      v10  <= v9;
      v11  <= vh;
      v12  <= v11;
      v13  <= v12;
      v14  <= v13;
      v15  <= vdiv2;
      done <= v15;
    end
  end

  // result checks
  a_count_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (point_count == cci_pkg::COUNT_NONE) || (point_count == cci_pkg::COUNT_ONE)
             || (point_count == cci_pkg::COUNT_TWO))
    else $error("point count out of range");

  a_b_cleared: assert property (@(posedge clk) disable iff (rst)
    (done && point_count != cci_pkg::COUNT_TWO) |-> (point_b_x == '0 && point_b_y == '0))
    else $error("second point not cleared");

  a_a_cleared: assert property (@(posedge clk) disable iff (rst)
    (done && point_count == cci_pkg::COUNT_NONE) |-> (point_a_x == '0 && point_a_y == '0))
    else $error("first point not cleared");

  a_tol_reset: assert property (@(posedge clk)
    ($past(rst) && !$past(cfg_write)) |-> tolerance == cci_pkg::TOL_RESET)
    else $error("tolerance not reset");

endmodule

@@ verif/cci_checker.sv @@
// result checker for the circle intersection block: watches requests,
// tolerance writes and results, predicts each result and compares
// depends on cci_pkg and on the port list of circle_circle_intersection
module cci_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                cfg_write,
  input  logic [cci_pkg::TOL_W-1:0]           cfg_data,
  input  logic signed [cci_pkg::COORD_W-1:0]  first_x,
  input  logic signed [cci_pkg::COORD_W-1:0]  first_y,
  input  logic [cci_pkg::RADIUS_W-1:0]        first_radius,
  input  logic signed [cci_pkg::COORD_W-1:0]  second_x,
  input  logic signed [cci_pkg::COORD_W-1:0]  second_y,
  input  logic [cci_pkg::RADIUS_W-1:0]        second_radius,
  input  logic                                done,
  input  logic [1:0]                          point_count,
  input  logic signed [cci_pkg::COORD_W-1:0]  point_a_x,
  input  logic signed [cci_pkg::COORD_W-1:0]  point_a_y,
  input  logic signed [cci_pkg::COORD_W-1:0]  point_b_x,
  input  logic signed [cci_pkg::COORD_W-1:0]  point_b_y,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  seen_none,
  output int                                  seen_one,
  output int                                  seen_two
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cci_pkg::count_t                   count;
    logic signed [cci_pkg::COORD_W-1:0] ax;
    logic signed [cci_pkg::COORD_W-1:0] ay;
    logic signed [cci_pkg::COORD_W-1:0] bx;
    logic signed [cci_pkg::COORD_W-1:0] by;
  } point_set_t;

  point_set_t                expected_points[$];
  logic [cci_pkg::TOL_W-1:0] tol_shadow;

  // integer square root, floor
  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return longint'(res);
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic longint quot_round(longint n, longint den);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + den / 2) / den;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [cci_pkg::COORD_W-1:0] clamp_coord(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[cci_pkg::COORD_W-1:0];
  endfunction

  // expected points for one pair of circles
  function automatic point_set_t intersect_circles(longint x1, longint y1, longint r1,
                                                   longint x2, longint y2, longint r2,
                                                   longint tol);
    point_set_t p;
    longint dx, dy, dq, low, high, d8, a8, h2, h8;
    p = '0;
    p.count = cci_pkg::COUNT_NONE;
    dx = x2 - x1;
    dy = y2 - y1;
    dq = dx * dx + dy * dy;
    low = ((r2 > r1) ? r2 - r1 : r1 - r2) + tol;
    high = r1 + r2 + tol;
    if (dq == 0 || dq < low * low || dq > high * high) return p;
    d8 = root_floor(longint'(dq) << 16);
    a8 = quot_round((r1 * r1 - r2 * r2 + dq) * 32768, d8);
    h2 = r1 * r1 * 65536 - a8 * a8;
    h8 = (h2 > 0) ? root_floor(h2) : 0;
    p.ax = clamp_coord(x1 + quot_round(a8 * dx - h8 * dy, d8));
    p.ay = clamp_coord(y1 + quot_round(a8 * dy + h8 * dx, d8));
    if (h8 <= tol * 256) begin
      p.count = cci_pkg::COUNT_ONE;
      return p;
    end
    p.count = cci_pkg::COUNT_TWO;
    p.bx = clamp_coord(x1 + quot_round(a8 * dx + h8 * dy, d8));
    p.by = clamp_coord(y1 + quot_round(a8 * dy - h8 * dx, d8));
    return p;
  endfunction

  assign pending = expected_points.size();

  // tolerance shadow and request capture
  always @(posedge clk) begin
    if (rst) begin
      tol_shadow <= cci_pkg::TOL_RESET;
      expected_points.delete();
    end else begin
      if (cfg_write) tol_shadow <= cfg_data;
      if (start && !busy)
        expected_points.insert(expected_points.size(),
                               intersect_circles(first_x, first_y, first_radius,
                                                 second_x, second_y, second_radius,
                                                 tol_shadow));
    end
  end

  // result compare against oldest prediction
  initial begin
    fail_count = 0;
    seen_none = 0;
    seen_one = 0;
    seen_two = 0;
  end

  always @(posedge clk) begin
    point_set_t want;
    if (!rst && done) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result, count %0d", $time, point_count);
        fail_count++;
      end else begin
        want = expected_points.pop_front();
        case (point_count)
          cci_pkg::COUNT_NONE: seen_none++;
          cci_pkg::COUNT_ONE:  seen_one++;
          default:             seen_two++;
        endcase
        if (point_count !== want.count) begin
          $display("%0t: point_count expected %0d actual %0d", $time, want.count, point_count);
          fail_count++;
        end
        if (point_a_x !== want.ax) begin
          $display("%0t: point_a_x expected %0d actual %0d", $time, want.ax, point_a_x);
          fail_count++;
        end
        if (point_a_y !== want.ay) begin
          $display("%0t: point_a_y expected %0d actual %0d", $time, want.ay, point_a_y);
          fail_count++;
        end
        if (point_b_x !== want.bx) begin
          $display("%0t: point_b_x expected %0d actual %0d", $time, want.bx, point_b_x);
          fail_count++;
        end
        if (point_b_y !== want.by) begin
          $display("%0t: point_b_y expected %0d actual %0d", $time, want.by, point_b_y);
          fail_count++;
        end
      end
    end
  end

endmodule

@@ verif/circle_circle_intersection_tb.sv @@
// testbench top for the circle intersection block: clock, reset, directed
// and random circle pairs over several tolerances; depends on cci_pkg,
// cci_checker and circle_circle_intersection
module circle_circle_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_PER_PHASE = 370;
  localparam int DRAIN_CYCLES = 200;

  logic                                clk;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic                                cfg_write;
  logic [cci_pkg::TOL_W-1:0]           cfg_data;
  logic signed [cci_pkg::COORD_W-1:0]  first_x, first_y, second_x, second_y;
  logic [cci_pkg::RADIUS_W-1:0]        first_radius, second_radius;
  logic                                done;
  logic [1:0]                          point_count;
  logic signed [cci_pkg::COORD_W-1:0]  point_a_x, point_a_y, point_b_x, point_b_y;
  int                                  fail_count, pending, seen_none, seen_one, seen_two;
  int                                  cycles;
  int                                  requests;

  circle_circle_intersection DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .first_x(first_x), .first_y(first_y), .first_radius(first_radius),
    .second_x(second_x), .second_y(second_y), .second_radius(second_radius),
    .done(done), .point_count(point_count),
    .point_a_x(point_a_x), .point_a_y(point_a_y),
    .point_b_x(point_b_x), .point_b_y(point_b_y)
  );

  cci_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .first_x(first_x), .first_y(first_y), .first_radius(first_radius),
    .second_x(second_x), .second_y(second_y), .second_radius(second_radius),
    .done(done), .point_count(point_count),
    .point_a_x(point_a_x), .point_a_y(point_a_y),
    .point_b_x(point_b_x), .point_b_y(point_b_y),
    .fail_count(fail_count), .pending(pending),
    .seen_none(seen_none), .seen_one(seen_one), .seen_two(seen_two)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one request and hold it until accepted, then maybe pause
  task automatic send_request(int x1, int y1, int r1, int x2, int y2, int r2);
    int gap;
    first_x <= x1[15:0];
    first_y <= y1[15:0];
    first_radius <= r1[14:0];
    second_x <= x2[15:0];
    second_y <= y2[15:0];
    second_radius <= r2[14:0];
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    requests++;
    case ($urandom_range(0, 99)) inside
      [0:54]:  gap = 0;
      [55:94]: gap = $urandom_range(1, 4);
      default: gap = $urandom_range(20, 150);
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // tolerance write while idle
  task automatic write_tolerance(int value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value[7:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int clip_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int clip_radius(int v);
    if (v > 32767) return 32767;
    if (v < 0) return 0;
    return v;
  endfunction

  // random pair: mostly overlapping or tangent circles, some noise
  task automatic send_random_pair();
    int x1, y1, x2, y2, dx, dy, r1, r2, span, mode;
    real d;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      send_request($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 32767), $urandom_range(0, 65535) - 32768,
                   $urandom_range(0, 65535) - 32768, $urandom_range(0, 32767));
    end else begin
      span = 1 << $urandom_range(0, 15);
      x1 = $urandom_range(0, 65535) - 32768;
      y1 = $urandom_range(0, 65535) - 32768;
      dx = $urandom_range(0, 2 * span) - span;
      dy = $urandom_range(0, 2 * span) - span;
      if (x1 + dx > 32767 || x1 + dx < -32768) dx = -dx;
      if (y1 + dy > 32767 || y1 + dy < -32768) dy = -dy;
      x2 = clip_coord(x1 + dx);
      y2 = clip_coord(y1 + dy);
      d = $sqrt(real'((x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1)));
      r1 = $urandom_range(0, (span * 2 > 32767) ? 32767 : span * 2);
      if (mode < 4) begin
        // tangent, outside or inside
        if ($urandom_range(0, 1)) r2 = clip_radius(int'(d) - r1);
        else r2 = clip_radius(r1 - int'(d));
        r2 = clip_radius(r2 + $urandom_range(0, 2) - 1);
      end else begin
        r2 = clip_radius($urandom_range(((int'(d) > r1) ? int'(d) - r1 : r1 - int'(d)),
                                        int'(d) + r1));
      end
      send_request(x1, y1, r1, x2, y2, r2);
    end
  endtask

  initial begin
    int tol_values[5];
    cycles = 0;
    requests = 0;
    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    first_x = '0;
    first_y = '0;
    first_radius = '0;
    second_x = '0;
    second_y = '0;
    second_radius = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs at reset tolerance
    send_request(0, 0, 4096, 0, 0, 4096);            // concentric, same radius
    send_request(100, -200, 4096, 100, -200, 8192);  // concentric, different radius
    send_request(0, 0, 4096, 8192, 0, 4096);         // outer tangent
    send_request(0, 0, 8192, 4096, 0, 4096);         // inner tangent
    send_request(0, 0, 4096, 20000, 0, 4096);        // apart
    send_request(0, 0, 16000, 100, 100, 100);        // one inside the other
    send_request(0, 0, 4096, 4096, 0, 4096);         // two points
    send_request(0, 0, 4096, 0, 4096, 4096);         // two points, vertical
    send_request(-32768, -32768, 32767, 32767, 32767, 32767);
    send_request(32767, 32767, 32767, -32768, -32768, 32767);
    send_request(32767, -32768, 32767, 32767, 32767, 32767);
    send_request(30000, 30000, 32767, 31000, 29000, 32767);  // points past the range
    send_request(-30000, -30000, 32767, -31000, -29000, 32767);
    send_request(0, 0, 0, 0, 1, 0);                  // zero radii, one lsb apart
    send_request(0, 0, 0, 1, 0, 1);
    send_request(5, 5, 1, 6, 5, 1);
    send_request(0, 0, 3, 4, 0, 1);                  // near tangent
    send_request(0, 0, 5000, 3000, 4000, 1);
    send_request(-1, -1, 32767, 0, 0, 0);
    send_request(-32768, 0, 16384, 0, 0, 16384);
    send_request(0, 32767, 100, 0, 32567, 100);

    tol_values[0] = 1;
    tol_values[1] = 0;
    tol_values[2] = 255;
    tol_values[3] = $urandom_range(2, 254);
    tol_values[4] = $urandom_range(0, 8);
    foreach (tol_values[i]) begin
      write_tolerance(tol_values[i]);
      if (i == 2) send_request(0, 0, 4096, 4096 + 400, 0, 4096);  // two points, at wide tolerance
      repeat (RANDOM_PER_PHASE) send_random_pair();
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests over 5 tolerance settings", requests);
    $display("results: %0d with no point, %0d with one, %0d with two",
             seen_none, seen_one, seen_two);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
